FILE: src/group_slot_bitmap_allocator_macros.svh
// assertion macros for the group slot bitmap allocator
`ifndef GROUP_SLOT_BITMAP_ALLOCATOR_MACROS_SVH
`define GROUP_SLOT_BITMAP_ALLOCATOR_MACROS_SVH

`ifndef SYNTHESIS

`define GSBA_ASSERT_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("gsba same-cycle check failed");

`define GSBA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("gsba next-cycle check failed");

`else

`define GSBA_ASSERT_SAME(label, clk, rstn, ante, cons)

`define GSBA_ASSERT_NEXT(label, clk, rstn, ante, cons)

`endif

`endif

FILE: src/gsba_pkg.sv
// shared types and codes of the group slot bitmap allocator
package gsba_pkg;

    localparam int ID_W       = 20;
    localparam int ASSIGNED_W = 21;
    localparam int OCC_W      = 32;
    localparam int HIGH_W     = 5;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_ADD_FAIL   = 2'd1,
        STATUS_REMOVE_OUT = 2'd2
    } status_t;

    typedef enum logic {
        ACTION_ADD    = 1'b0,
        ACTION_REMOVE = 1'b1
    } action_t;

    typedef struct packed {
        logic                  group_empty;
        logic [HIGH_W-1:0]     highest_slot;
        logic [OCC_W-1:0]      occupancy;
        logic [ASSIGNED_W-1:0] assigned_id;
        status_t               status;
    } result_t;

endpackage

FILE: src/gsba_engine.sv
// slot search, mask update and result formation for one add or remove
module gsba_engine #(
    parameter int SLOT_COUNT = 32
) (
    input  gsba_pkg::action_t               action,
    input  logic [gsba_pkg::ID_W-1:0]       member_id,
    input  logic [gsba_pkg::ID_W-1:0]       base_id,
    input  logic [SLOT_COUNT-1:0]           mask_cur,
    input  logic [$clog2(SLOT_COUNT)-1:0]   ptr_cur,
    output logic [SLOT_COUNT-1:0]           mask_next,
    output logic [$clog2(SLOT_COUNT)-1:0]   ptr_next,
    output gsba_pkg::result_t               result
);
    import gsba_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(SLOT_COUNT - 1);
    localparam logic [SLOT_COUNT-1:0] ALL_ONES = {SLOT_COUNT{1'b1}};

    logic [SLOT_COUNT-1:0] free_all;
    logic [SLOT_COUNT-1:0] free_upper;
    logic [IDX_W-1:0]      low_upper;
    logic [IDX_W-1:0]      low_all;
    logic [IDX_W-1:0]      auto_slot;
    logic                  auto_found;
    logic [ID_W:0]         offset;
    logic                  in_range;
    logic [IDX_W-1:0]      id_slot;
    logic [IDX_W-1:0]      pick_slot;
    logic                  pick_ok;
    logic [IDX_W-1:0]      high_idx;
    logic                  auto_add;
    status_t               status_sel;
    logic [ASSIGNED_W-1:0] assigned_sel;

    assign free_all   = ~mask_cur;
    assign free_upper = free_all & (ALL_ONES << ptr_cur);

    // lowest free slot at or after the pointer, and from slot zero
    always_comb begin
        low_upper = '0;
        low_all   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (free_upper[i]) begin
                low_upper = IDX_W'(i);
            end
            if (free_all[i]) begin
                low_all = IDX_W'(i);
            end
        end
    end

    assign auto_found = |free_all;
    assign auto_slot  = (|free_upper) ? low_upper : low_all;

    assign offset   = {1'b0, member_id} - {1'b0, base_id};
    assign in_range = (member_id >= base_id) && (offset < (ID_W + 1)'(SLOT_COUNT));
    assign id_slot  = offset[IDX_W-1:0];

    assign auto_add = (action == ACTION_ADD) && (member_id == '0);

    always_comb begin
        pick_slot = id_slot;
        pick_ok   = in_range && !mask_cur[id_slot];
        if (auto_add) begin
            pick_slot = auto_slot;
            pick_ok   = auto_found;
        end
    end

    always_comb begin
        mask_next    = mask_cur;
        status_sel   = STATUS_OK;
        assigned_sel = '0;
        unique case (action)
            ACTION_ADD: begin
                if (pick_ok) begin
                    mask_next[pick_slot] = 1'b1;
                    assigned_sel         = ASSIGNED_W'(base_id) + ASSIGNED_W'(pick_slot);
                end else begin
                    status_sel = STATUS_ADD_FAIL;
                end
            end
            ACTION_REMOVE: begin
                if (in_range) begin
                    mask_next[id_slot] = 1'b0;
                end else begin
                    status_sel = STATUS_REMOVE_OUT;
                end
            end
            default: begin
                status_sel = STATUS_OK;
            end
        endcase
    end

    assign ptr_next = auto_add ? ((ptr_cur == LAST_SLOT) ? '0 : ptr_cur + 1'b1) : ptr_cur;

    always_comb begin
        high_idx = '0;
        for (int i = 0; i < SLOT_COUNT; i++) begin
            if (mask_next[i]) begin
                high_idx = IDX_W'(i);
            end
        end
    end

    // fields from the top bit down: empty flag, highest slot, mask, granted id, status
    assign result = {~|mask_next, HIGH_W'(high_idx), OCC_W'(mask_next), assigned_sel,
                     status_sel};

endmodule

FILE: src/group_slot_bitmap_allocator.sv
// top level of the group slot bitmap allocator
//
//  port group   dir   contents
//  s_*          in    add or remove request word
//  m_*          out   status, granted id, occupancy mask, highest slot, empty flag
//  cfg_*        in    group base id
//
// one word a cycle sustained while m_tready is high; a word passes the input register,
// then the slot search and mask update in one pass into the result register
// the mask and search pointer update as a word leaves the input register
// reset clears the mask, the pointer, the base id and both valid flags
// a stall on m_tready holds both stages and drops s_tready once they are full
`include "group_slot_bitmap_allocator_macros.svh"

module group_slot_bitmap_allocator #(
    parameter int SLOT_COUNT = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [gsba_pkg::ID_W-1:0] cfg_wr_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [23:0]               s_tdata,   // member_id[19:0], zero pad
    input  logic                      s_tuser,   // action
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // status[1:0], assigned_id[22:2], occupancy[54:23], highest_slot[59:55],
    // group_empty[60], zero pad
    output logic [63:0]               m_tdata
);
    import gsba_pkg::*;

    localparam int IDX_W = $clog2(SLOT_COUNT);

    logic                  in_valid_reg;
    action_t               in_action_reg;
    logic [ID_W-1:0]       in_id_reg;
    logic                  out_valid_reg;
    result_t               out_result_reg;
    logic [SLOT_COUNT-1:0] mask_reg;
    logic [SLOT_COUNT-1:0] mask_next;
    logic [IDX_W-1:0]      ptr_reg;
    logic [IDX_W-1:0]      ptr_next;
    logic [ID_W-1:0]       base_reg;
    result_t               result_next;
    logic                  advance;
    logic                  s_fire;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_fire   = s_tvalid && s_tready;

    gsba_engine #(
        .SLOT_COUNT (SLOT_COUNT)
    ) u_engine (
        .action    (in_action_reg),
        .member_id (in_id_reg),
        .base_id   (base_reg),
        .mask_cur  (mask_reg),
        .ptr_cur   (ptr_reg),
        .mask_next (mask_next),
        .ptr_next  (ptr_next),
        .result    (result_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mask_reg      <= '0;
            ptr_reg       <= '0;
            base_reg      <= '0;
        end else begin
            if (cfg_wr_en) begin
                base_reg <= cfg_wr_data;
            end
            if (s_fire) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                mask_reg      <= mask_next;
                ptr_reg       <= ptr_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_action_reg <= action_t'(s_tuser);
            in_id_reg     <= s_tdata[ID_W-1:0];
        end
        if (advance) begin
            out_result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, out_result_reg};

    `GSBA_ASSERT_NEXT(a_advance_fills_output, aclk, aresetn, advance, out_valid_reg)
    `GSBA_ASSERT_NEXT(a_auto_add_moves_ptr, aclk, aresetn,
        advance && in_action_reg == ACTION_ADD && in_id_reg == '0, ptr_reg != $past(ptr_reg))
    `GSBA_ASSERT_NEXT(a_grant_sets_mask, aclk, aresetn,
        advance && in_action_reg == ACTION_ADD && result_next.status == STATUS_OK,
        mask_reg != '0)
    `GSBA_ASSERT_SAME(a_empty_has_no_high, aclk, aresetn,
        out_valid_reg && out_result_reg.group_empty, out_result_reg.highest_slot == '0)

endmodule

FILE: bench/group_slot_bitmap_allocator_test.sv
// self-checking testbench for the group slot bitmap allocator
`timescale 1ns / 100ps

module group_slot_bitmap_allocator_test;
    import gsba_pkg::*;

    localparam int SLOTS       = 32;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 4;
    localparam int CYCLE_LIMIT = 500000;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [ID_W-1:0]     cfg_wr_data = '0;
    logic                s_tvalid    = 1'b0;
    logic                s_tready;
    logic [23:0]         s_tdata     = '0;
    logic                s_tuser     = 1'b0;
    logic                m_tvalid;
    logic                m_tready    = 1'b0;
    logic [63:0]         m_tdata;

    // allocator state as the bench sees it
    logic [SLOTS-1:0]    occ_mask    = '0;
    logic [HIGH_W-1:0]   search_slot = '0;
    logic [ID_W-1:0]     group_base  = '0;

    result_t             outcome_q[$];
    result_t             want;
    result_t             seen;
    int                  fault_count   = 0;
    int                  cycle_count   = 0;
    bit                  tx_gaps_on    = 1'b0;
    bit                  rx_gaps_on    = 1'b0;
    int                  hold_requests = 0;
    int                  hold_served   = 0;
    int                  rx_wait       = 0;

    group_slot_bitmap_allocator #(
        .SLOT_COUNT(SLOTS)
    ) u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int slot_of(logic [ID_W-1:0] id);
        logic [ID_W-1:0] off;
        if (id < group_base) return SLOTS;
        off = id - group_base;
        return (off < SLOTS) ? int'(off) : SLOTS;
    endfunction

    function automatic result_t apply_request(action_t act, logic [ID_W-1:0] id);
        result_t r;
        int      slot;
        int      i;
        r = '0;
        r.status = STATUS_OK;
        if (act == ACTION_ADD) begin
            if (id == '0) begin
                slot = SLOTS;
                for (i = int'(search_slot); i < SLOTS; i++) begin
                    if (!occ_mask[i] && slot == SLOTS) slot = i;
                end
                for (i = 0; i < SLOTS; i++) begin
                    if (!occ_mask[i] && slot == SLOTS) slot = i;
                end
                search_slot = search_slot + 1'b1;
            end else begin
                slot = slot_of(id);
            end
            if (slot >= SLOTS || occ_mask[slot]) begin
                r.status = STATUS_ADD_FAIL;
            end else begin
                occ_mask[slot] = 1'b1;
                r.assigned_id = ASSIGNED_W'(group_base) + ASSIGNED_W'(slot);
            end
        end else begin
            slot = slot_of(id);
            if (slot >= SLOTS) r.status = STATUS_REMOVE_OUT;
            else occ_mask[slot] = 1'b0;
        end
        r.occupancy = occ_mask;
        for (i = 0; i < SLOTS; i++) begin
            if (occ_mask[i]) r.highest_slot = HIGH_W'(i);
        end
        r.group_empty = (occ_mask == '0);
        return r;
    endfunction

    function automatic void compare_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
            fault_count++;
        end
    endfunction

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // result word checker
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected word, expected none, got %h", $time, m_tdata);
                fault_count++;
            end else begin
                want = outcome_q.pop_front();
                seen = m_tdata[60:0];
                compare_field("status", want.status, seen.status);
                compare_field("assigned_id", want.assigned_id, seen.assigned_id);
                compare_field("occupancy", want.occupancy, seen.occupancy);
                compare_field("highest_slot", want.highest_slot, seen.highest_slot);
                compare_field("group_empty", want.group_empty, seen.group_empty);
            end
        end
    end

    // receiver pacing with long hold-offs on request
    always @(negedge aclk) begin
        if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            rx_wait = HOLD_CYCLES;
        end
        if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (rx_gaps_on) rx_wait = gap_len();
        end
    end

    task automatic send_request(input action_t act, input logic [ID_W-1:0] id);
        int gap;
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0, id};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        outcome_q.push_back(apply_request(act, id));
        if (tx_gaps_on) begin
            gap = gap_len();
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
    endtask

    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_base(input logic [ID_W-1:0] base);
        wait_idle();
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= base;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        group_base = base;
    endtask

    task automatic send_random_request(input int add_pct);
        action_t         act;
        logic [ID_W-1:0] id;
        if ($urandom_range(0, 99) < 12) begin
            act = action_t'($urandom_range(0, 1));
            case ($urandom_range(0, 3))
                0: id = ID_W'($urandom);
                1: id = group_base - 1'b1;
                2: id = group_base + ID_W'(SLOTS);
                default: id = group_base + ID_W'($urandom_range(SLOTS, SLOTS + 8));
            endcase
        end else if ($urandom_range(0, 99) < add_pct) begin
            act = ACTION_ADD;
            if ($urandom_range(0, 1)) id = '0;
            else id = group_base + ID_W'($urandom_range(0, SLOTS - 1));
        end else begin
            act = ACTION_REMOVE;
            id  = group_base + ID_W'($urandom_range(0, SLOTS - 1));
        end
        send_request(act, id);
    endtask

    task automatic test_edge_ids();
        set_base(20'd100);
        send_request(ACTION_ADD, 20'd0);
        send_request(ACTION_ADD, 20'd131);
        send_request(ACTION_ADD, 20'd131);
        send_request(ACTION_ADD, 20'd99);
        send_request(ACTION_ADD, 20'd132);
        send_request(ACTION_ADD, 20'hFFFFF);
        send_request(ACTION_REMOVE, 20'd99);
        send_request(ACTION_REMOVE, 20'd132);
        send_request(ACTION_REMOVE, 20'd105);
        send_request(ACTION_REMOVE, 20'd131);
        send_request(ACTION_REMOVE, 20'hFFFFF);
        send_request(ACTION_REMOVE, 20'd100);
    endtask

    task automatic test_base_zero();
        set_base(20'd0);
        send_request(ACTION_ADD, 20'd0);
        send_request(ACTION_ADD, 20'd31);
        send_request(ACTION_ADD, 20'd32);
        send_request(ACTION_REMOVE, 20'd0);
        send_request(ACTION_REMOVE, 20'd31);
        send_request(ACTION_REMOVE, 20'd1);
    endtask

    task automatic test_base_max();
        set_base(20'hFFFFF);
        send_request(ACTION_ADD, 20'hFFFFF);
        send_request(ACTION_ADD, 20'd0);
        send_request(ACTION_REMOVE, 20'hFFFFE);
        send_request(ACTION_REMOVE, 20'd0);
        send_request(ACTION_REMOVE, 20'hFFFFF);
        send_request(ACTION_ADD, 20'd1);
    endtask

    task automatic test_fill_and_wrap();
        int k;
        set_base(20'h007F0);
        tx_gaps_on = 1'b1;
        rx_gaps_on = 1'b1;
        for (k = 0; k < SLOTS; k++) send_request(ACTION_REMOVE, group_base + ID_W'(k));
        for (k = 0; k < SLOTS + 4; k++) send_request(ACTION_ADD, 20'd0);
        send_request(ACTION_REMOVE, group_base + 20'd3);
        send_request(ACTION_REMOVE, group_base + 20'd17);
        send_request(ACTION_REMOVE, group_base + 20'd30);
        for (k = 0; k < 5; k++) send_request(ACTION_ADD, 20'd0);
    endtask

    task automatic test_backpressure();
        int k;
        wait_idle();
        tx_gaps_on = 1'b0;
        rx_gaps_on = 1'b0;
        hold_requests++;
        for (k = 0; k < 48; k++) send_random_request(55);
        wait_idle();
    endtask

    task automatic test_random_traffic(input logic [ID_W-1:0] base, input int count,
                                       input int add_pct, input bit tx_gaps, input bit rx_gaps);
        int k;
        set_base(base);
        tx_gaps_on = tx_gaps;
        rx_gaps_on = rx_gaps;
        for (k = 0; k < count; k++) send_random_request(add_pct);
    endtask

    initial begin
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;
        test_edge_ids();
        test_base_zero();
        test_base_max();
        test_fill_and_wrap();
        test_random_traffic(20'd0, 140, 75, 1'b1, 1'b1);
        test_random_traffic(20'hFFFE0, 140, 40, 1'b0, 1'b0);
        test_backpressure();
        test_random_traffic(ID_W'($urandom_range(0, 20'hFFFE0)), 140, 60, 1'b1, 1'b0);
        test_random_traffic(ID_W'($urandom_range(0, 20'hFFFE0)), 140, 30, 1'b0, 1'b1);
        test_random_traffic(20'd1, 140, 80, 1'b1, 1'b1);
        test_random_traffic(ID_W'($urandom_range(0, 20'hFFFE0)), 140, 50, 1'b1, 1'b1);
        test_random_traffic(ID_W'($urandom_range(0, 63)), 140, 55, 1'b1, 1'b1);
        wait_idle();
        if (fault_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
